FILE: src/pack_block_store_crc8_defines.svh
// Assertion macros used by the checker file.
`ifndef PACK_BLOCK_STORE_CRC8_DEFINES_SVH
`define PACK_BLOCK_STORE_CRC8_DEFINES_SVH

// same-cycle implication on the block clock, off during reset
`define PBS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the block clock, off during reset
`define PBS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/pbs_crc8_pkg.sv
package pbs_crc8_pkg;

   localparam int BLOCK_COUNT = 1024;
   localparam int BLOCK_BYTES = 32;
   localparam int STORE_DEPTH = BLOCK_COUNT * BLOCK_BYTES;
   localparam int IDX_W       = 5;
   localparam int ADDR_IN_W   = 11;
   localparam int BYTE_W      = 8;
   localparam int BLOCK_AW    = $clog2(BLOCK_COUNT);
   localparam int STORE_AW    = BLOCK_AW + IDX_W;

   localparam logic [BYTE_W-1:0] CRC_POLY   = 8'h85;
   localparam logic [BYTE_W-1:0] ERASED     = 8'hFF;
   localparam logic [BYTE_W-1:0] RUMBLE_HI  = 8'h80;
   localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(BLOCK_BYTES - 1);
   localparam logic [IDX_W-1:0]  FIRST_IDX  = '0;

   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // where the returned byte comes from
   typedef logic [1:0] src_type;
   localparam src_type SRC_MEM  = 2'd0;
   localparam src_type SRC_ECHO = 2'd1;
   localparam src_type SRC_ZERO = 2'd2;
   localparam src_type SRC_HIGH = 2'd3;

   // one byte of CRC-8, MSB first
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0] r;
      r = crc ^ data;
      for (int i = 0; i < BYTE_W; i++) begin
         if (r[BYTE_W-1]) begin
            r = {r[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[BYTE_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

FILE: src/pbs_crc8_channels.sv
interface pbs_crc8_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 kind;
   logic [pbs_crc8_pkg::ADDR_IN_W-1:0]   block_address;
   logic [pbs_crc8_pkg::IDX_W-1:0]       byte_index;
   logic [pbs_crc8_pkg::BYTE_W-1:0]      data_in;

   modport source (output valid, kind, block_address, byte_index, data_in, input ready);
   modport sink   (input valid, kind, block_address, byte_index, data_in, output ready);
endinterface

interface pbs_crc8_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [pbs_crc8_pkg::BYTE_W-1:0]  data_out;
   logic [pbs_crc8_pkg::BYTE_W-1:0]  crc_out;
   logic                             crc_valid;

   modport source (output valid, data_out, crc_out, crc_valid, input ready);
   modport sink   (input valid, data_out, crc_out, crc_valid, output ready);
endinterface

FILE: src/pack_block_store_crc8.sv
// Pipeline: memory read into the stage 1 register, then CRC and the output register.
// Throughput: 1 item per cycle sustained while results are taken; the single read port of
// the byte store and the output register set the pace, and a stalled result holds the item
// behind it in place. Reset (synchronous): store erase pass writes 0xFF to every byte, one
// per cycle, across all STORE_DEPTH (32768) bytes with req ready low; CRC is 0, rumble mode is 1.
module pack_block_store_crc8 (
   input  logic                  clock,
   input  logic                  reset,
   pbs_crc8_req_if.sink          req_bus,
   pbs_crc8_rsp_if.source        rsp_bus,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);

   logic                                  rumble_ff, rumble_in;
   logic                                  clr_busy_ff, clr_busy_in;
   logic [pbs_crc8_pkg::STORE_AW-1:0]     clr_addr_ff, clr_addr_in;

   logic                                  s1_valid_ff, s1_valid_in;
   pbs_crc8_pkg::src_type                 s1_src_ff;
   logic                                  s1_first_ff;
   logic                                  s1_last_ff;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       s1_data_ff;

   logic [pbs_crc8_pkg::BYTE_W-1:0]       crc_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       rsp_data_ff;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       rsp_crc_ff;
   logic                                  rsp_last_ff;

   logic                                  accept;
   logic                                  out_free;
   logic                                  s1_move;
   logic                                  in_range;
   pbs_crc8_pkg::src_type                 src_sel;
   logic [pbs_crc8_pkg::STORE_AW-1:0]     item_pos;
   logic                                  store_wr;

   logic                                  ram_wr_en;
   logic [pbs_crc8_pkg::STORE_AW-1:0]     ram_wr_addr;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       ram_wr_data;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       ram_rd_data;

   logic [pbs_crc8_pkg::BYTE_W-1:0]       dout;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       crc_seed;
   logic [pbs_crc8_pkg::BYTE_W-1:0]       crc_next;

   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign s1_move       = s1_valid_ff && out_free;
   assign req_bus.ready = !clr_busy_ff && (!s1_valid_ff || out_free);
   assign accept        = req_bus.valid && req_bus.ready;

   assign in_range = {1'b0, req_bus.block_address} <
                     (pbs_crc8_pkg::ADDR_IN_W + 1)'(pbs_crc8_pkg::BLOCK_COUNT);
   assign item_pos = {req_bus.block_address[pbs_crc8_pkg::BLOCK_AW-1:0],
                      req_bus.byte_index};

   always_comb begin
      if (req_bus.kind == pbs_crc8_pkg::KIND_WRITE) begin
         src_sel = pbs_crc8_pkg::SRC_ECHO;
      end else if (rumble_ff) begin
         src_sel = in_range ? pbs_crc8_pkg::SRC_ZERO : pbs_crc8_pkg::SRC_HIGH;
      end else begin
         src_sel = in_range ? pbs_crc8_pkg::SRC_MEM : pbs_crc8_pkg::SRC_ZERO;
      end
   end

   assign store_wr = accept && (req_bus.kind == pbs_crc8_pkg::KIND_WRITE) &&
                     !rumble_ff && in_range;

   // erase pass owns the write port; items are held off until it ends
   assign ram_wr_en   = clr_busy_ff || store_wr;
   assign ram_wr_addr = clr_busy_ff ? clr_addr_ff : item_pos;
   assign ram_wr_data = clr_busy_ff ? pbs_crc8_pkg::ERASED : req_bus.data_in;

   pbs_crc8_ram #(
      .WIDTH (pbs_crc8_pkg::BYTE_W),
      .DEPTH (pbs_crc8_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (item_pos),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      case (s1_src_ff)
         pbs_crc8_pkg::SRC_MEM:  dout = ram_rd_data;
         pbs_crc8_pkg::SRC_ECHO: dout = s1_data_ff;
         pbs_crc8_pkg::SRC_HIGH: dout = pbs_crc8_pkg::RUMBLE_HI;
         default:                dout = '0;
      endcase
   end

   assign crc_seed = s1_first_ff ? '0 : crc_ff;
   assign crc_next = pbs_crc8_pkg::crc8_step(crc_seed, dout);

   always_comb begin
      rumble_in   = csr_wr_en ? csr_wr_data : rumble_ff;
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == pbs_crc8_pkg::STORE_AW'(pbs_crc8_pkg::STORE_DEPTH - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rumble_ff    <= 1'b1;
         clr_busy_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         crc_ff       <= '0;
      end else begin
         rumble_ff    <= rumble_in;
         clr_busy_ff  <= clr_busy_in;
         clr_addr_ff  <= clr_addr_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_move) begin
            crc_ff <= crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_src_ff   <= src_sel;
         s1_first_ff <= req_bus.byte_index == pbs_crc8_pkg::FIRST_IDX;
         s1_last_ff  <= req_bus.byte_index == pbs_crc8_pkg::LAST_IDX;
         s1_data_ff  <= req_bus.data_in;
      end
      if (s1_move) begin
         rsp_data_ff <= dout;
         rsp_crc_ff  <= s1_last_ff ? crc_next : '0;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.data_out  = rsp_data_ff;
   assign rsp_bus.crc_out   = rsp_crc_ff;
   assign rsp_bus.crc_valid = rsp_last_ff;

endmodule

FILE: src/pbs_crc8_ram.sv
module pbs_crc8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/pbs_crc8_chk.sv
`include "pack_block_store_crc8_defines.svh"

module pbs_crc8_chk (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [pbs_crc8_pkg::BYTE_W-1:0]     rsp_data_out,
   input logic [pbs_crc8_pkg::BYTE_W-1:0]     rsp_crc_out,
   input logic                                rsp_crc_valid
);

   // CRC field is zero except on the last byte of a block
   `PBS_ASSERT_NOW(a_crc_zero_off_last, rsp_valid && !rsp_crc_valid, rsp_crc_out == '0, "crc_out nonzero without crc_valid")

   // erase pass keeps items out right after reset
   `PBS_ASSERT_NOW(a_busy_after_reset, $past(reset), !req_ready, "item taken during store erase")

   // stalled result keeps its payload
   `PBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data_out) && $stable(rsp_crc_out) && $stable(rsp_crc_valid), "stalled result changed")

endmodule

bind pack_block_store_crc8 pbs_crc8_chk u_pbs_crc8_chk (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_data_out  (rsp_bus.data_out),
   .rsp_crc_out   (rsp_bus.crc_out),
   .rsp_crc_valid (rsp_bus.crc_valid)
);
